// ===== rtl/core/cbts_pkg.sv =====
package cbts_pkg;

  localparam int TRACKED_IDS = 32;
  localparam int TBL_AW      = $clog2(TRACKED_IDS);
  localparam int CNT_W       = $clog2(TRACKED_IDS + 1);
  localparam int ID_W        = 29;
  localparam int BAUD_W      = 20;
  localparam int KIND_COUNTS = 5;

  localparam logic [BAUD_W-1:0] BAUD_RESET = 20'd500000;

  // request codes
  localparam logic [1:0] REQ_FRAME  = 2'd0;
  localparam logic [1:0] REQ_STATUS = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_LOST   = 2'd3;

  // result codes
  localparam logic [2:0] RES_FRAME   = 3'd0;
  localparam logic [2:0] RES_ERROR   = 3'd1;
  localparam logic [2:0] RES_SUMMARY = 3'd2;
  localparam logic [2:0] RES_RATE    = 3'd3;
  localparam logic [2:0] RES_DROP    = 3'd4;

  // bus states
  localparam logic [1:0] BUS_ACTIVE  = 2'd0;
  localparam logic [1:0] BUS_PASSIVE = 2'd1;
  localparam logic [1:0] BUS_OFF     = 2'd2;

  // error kinds
  localparam logic [2:0] EK_OTHER = 3'd0;
  localparam logic [2:0] EK_STUFF = 3'd1;
  localparam logic [2:0] EK_FORM  = 3'd2;
  localparam logic [2:0] EK_ACK   = 3'd3;
  localparam logic [2:0] EK_CRC   = 3'd4;
  localparam logic [2:0] EK_BIT0  = 3'd5;
  localparam logic [2:0] EK_BIT1  = 3'd6;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [ID_W-1:0] arb_id;
    logic [3:0]      data_len;
    logic            extended;
    logic            protocol_error;
    logic [2:0]      error_kind;
    logic            bus_off_flag;
    logic            passive_flag;
  } in_t;

  typedef struct packed {
    logic [2:0]      result_kind;
    logic            last_item;
    logic [4:0]      table_index;
    logic [ID_W-1:0] id_value;
    logic            id_tracked;
    logic [7:0]      frame_bits;
    logic [31:0]     count_value;
    logic [15:0]     utilization_bp;
    logic [31:0]     error_rate;
    logic [1:0]      bus_state;
  } out_t;

  typedef struct packed {
    logic              key_en;
    logic              cnt_en;
    logic [TBL_AW-1:0] addr;
    logic [ID_W-1:0]   key;
    logic [31:0]       cnt;
  } tbl_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FRAME_OUT,
    ST_ERR_OUT,
    ST_DROP_OUT,
    ST_DIV,
    ST_SUM_OUT,
    ST_WALK_RD,
    ST_WALK_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHK,
    DV_RUN
  } div_state_t;

  // floor((44 or 68 + 8*dlc) * 11 / 10); /10 as *6554 >> 16, exact below 2^14
  function automatic logic [7:0] frame_bits(input logic ext, input logic [3:0] dlc);
    logic [7:0]  raw;
    logic [11:0] x;
    logic [24:0] p;
    raw = (ext ? 8'd68 : 8'd44) + {1'b0, dlc, 3'b000};
    x   = {4'b0000, raw} * 12'd11;
    p   = {13'b0, x} * 25'd6554;
    return p[23:16];
  endfunction

endpackage

// ===== rtl/core/cbts_id_table.sv =====
module cbts_id_table (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [cbts_pkg::TBL_AW-1:0] rd_addr,
  input  cbts_pkg::tbl_wr_t       wr,
  output logic [cbts_pkg::ID_W-1:0] rd_key,
  output logic [31:0]             rd_cnt
);
  import cbts_pkg::*;

  logic [ID_W-1:0] keys [TRACKED_IDS];
  logic [31:0]     cnts [TRACKED_IDS];

  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      keys[wr.addr] <= wr.key;
    end
    if (wr.cnt_en) begin
      cnts[wr.addr] <= wr.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= keys[rd_addr];
      rd_cnt <= cnts[rd_addr];
    end
  end

endmodule

// ===== rtl/core/cbts_util_div.sv =====
module cbts_util_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 bits,
  input  logic [cbts_pkg::BAUD_W-1:0] baud,
  output logic                        done,
  output logic [15:0]                 util
);
  import cbts_pkg::*;

  div_state_t        dstate, dstate_next;
  logic [31:0]       bits_q;
  logic [BAUD_W-1:0] baud_q;
  logic [45:0]       prod;
  logic [BAUD_W:0]   rem;
  logic [15:0]       quo;
  logic [3:0]        step;
  logic [BAUD_W:0]   trial;
  logic              take;
  logic [15:0]       quo_next;
  logic              sat;

  assign trial    = {rem[BAUD_W-1:0], quo[15]};
  assign take     = trial >= {1'b0, baud_q};
  assign quo_next = {quo[14:0], take};
  // quotient cannot fit 16 bits (also covers a zero rate)
  assign sat      = prod >= {10'b0, baud_q, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= DV_IDLE;
    end else begin
      dstate <= dstate_next;
    end
  end

  always_comb begin
    dstate_next = dstate;
    case (dstate)
      DV_IDLE: if (start) dstate_next = DV_MUL;
      DV_MUL:  dstate_next = DV_CHK;
      DV_CHK:  dstate_next = sat ? DV_IDLE : DV_RUN;
      DV_RUN:  if (step == 4'd15) dstate_next = DV_IDLE;
      default: dstate_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((dstate == DV_CHK) && sat) || ((dstate == DV_RUN) && (step == 4'd15));
    end
  end

  always_ff @(posedge clk) begin
    case (dstate)
      DV_IDLE: begin
        if (start) begin
          bits_q <= bits;
          baud_q <= baud;
        end
      end
      DV_MUL: begin
        prod <= {14'b0, bits_q} * 46'd10000;
      end
      DV_CHK: begin
        rem  <= {1'b0, prod[35:16]};
        quo  <= prod[15:0];
        step <= 4'd0;
        if (sat) begin
          util <= 16'hFFFF;
        end
      end
      DV_RUN: begin
        rem  <= take ? (trial - {1'b0, baud_q}) : trial;
        quo  <= quo_next;
        step <= step + 4'd1;
        if (step == 4'd15) begin
          util <= quo_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/can_bus_traffic_statistics_top.sv =====
// Channel  Handshake            Payload                Role
// in       in_valid / in_stall  in_data  (in_t)        one request: frame, status, tick, lost
// out      out_valid / out_stall out_data (out_t)      one result item per transfer
// cfg      cfg_wr_en            cfg_wr_data (20 bits)  nominal bit rate
//
// One request at a time. A frame walks the ID table one slot per cycle over the
// table's single read port. A window tick runs the utilization divider (1 bit
// per cycle), then reads, reports and clears each tracked ID in table order.
// Status and lost requests each give a single result item.
// rst is synchronous; it clears control, counters and bus state. Table contents
// are not cleared: only slots below tracked_count are ever read.
// A stalled output holds the sequencer; the output register lets the last
// result of a request wait while the next request is accepted.
module can_bus_traffic_statistics_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  cbts_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cbts_pkg::out_t              out_data,
  input  logic                        cfg_wr_en,
  input  logic [cbts_pkg::BAUD_W-1:0] cfg_wr_data
);
  import cbts_pkg::*;

  state_t state, state_next;

  logic [BAUD_W-1:0] baud_rate;
  in_t               in_q;
  logic              in_acc;

  // window and global counters
  logic [CNT_W-1:0]  tracked_count;
  logic [31:0]       bits_accum;
  logic [31:0]       window_errors;
  logic [31:0]       kind_cnt [KIND_COUNTS];
  logic [31:0]       dropped_total;
  logic [1:0]        state_of_bus;

  // table scan / walk
  logic [CNT_W-1:0]  ptr;
  logic              pend;
  logic [TBL_AW-1:0] pidx;
  logic              tbl_rd_en;
  logic [TBL_AW-1:0] tbl_rd_addr;
  tbl_wr_t           tbl_wr;
  logic [ID_W-1:0]   rd_key;
  logic [31:0]       rd_cnt;
  logic              hit;
  logic              miss;
  logic              room;
  logic              walk_last;

  // per-request results
  logic [TBL_AW-1:0] fr_slot;
  logic              fr_trk;
  logic [31:0]       fr_cnt;
  logic [7:0]        fr_bits;
  logic [31:0]       err_cnt;
  logic [15:0]       util_q;

  // status decode
  logic              ek_valid;
  logic [2:0]        ek_idx;

  // utilization divider
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_util;

  // output stage
  logic              out_free;
  logic              emit_en;
  out_t              emit_res;

  logic [7:0]        fb_now;
  logic [32:0]       bits_sum;

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign room      = tracked_count < CNT_W'(TRACKED_IDS);
  assign hit       = (state == ST_SCAN) && pend && (rd_key == in_q.arb_id);
  assign miss      = (state == ST_SCAN) && !pend && (ptr >= tracked_count);
  assign walk_last = CNT_W'(ptr + 1'b1) == tracked_count;
  assign fb_now    = frame_bits(in_q.extended, in_q.data_len);
  assign bits_sum  = {1'b0, bits_accum} + {25'b0, fb_now};
  assign div_start = in_acc && (in_data.req_type == REQ_TICK);

  always_comb begin
    ek_valid = 1'b1;
    ek_idx   = 3'd0;
    case (in_data.error_kind)
      EK_STUFF: ek_idx = 3'd0;
      EK_FORM:  ek_idx = 3'd1;
      EK_ACK:   ek_idx = 3'd2;
      EK_CRC:   ek_idx = 3'd3;
      EK_BIT0:  ek_idx = 3'd4;
      EK_BIT1:  ek_idx = 3'd4;
      default:  ek_valid = 1'b0;
    endcase
  end

  cbts_id_table u_table (
    .clk     (clk),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .wr      (tbl_wr),
    .rd_key  (rd_key),
    .rd_cnt  (rd_cnt)
  );

  cbts_util_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .bits  (bits_accum),
    .baud  (baud_rate),
    .done  (div_done),
    .util  (div_util)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, table access, result build
  always_comb begin
    state_next  = state;
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = ptr[TBL_AW-1:0];
    tbl_wr      = '0;
    emit_en     = 1'b0;
    emit_res    = '0;
    emit_res.bus_state = state_of_bus;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.req_type)
            REQ_FRAME:  state_next = ST_SCAN;
            REQ_STATUS: state_next = ST_ERR_OUT;
            REQ_TICK:   state_next = ST_DIV;
            REQ_LOST:   state_next = ST_DROP_OUT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          tbl_wr.cnt_en = 1'b1;
          tbl_wr.addr   = pidx;
          tbl_wr.cnt    = rd_cnt + 32'd1;
          state_next    = ST_FRAME_OUT;
        end else if (miss) begin
          if (room) begin
            tbl_wr.key_en = 1'b1;
            tbl_wr.cnt_en = 1'b1;
            tbl_wr.addr   = tracked_count[TBL_AW-1:0];
            tbl_wr.key    = in_q.arb_id;
            tbl_wr.cnt    = 32'd1;
          end
          state_next = ST_FRAME_OUT;
        end else begin
          tbl_rd_en = ptr < tracked_count;
        end
      end
      ST_FRAME_OUT: begin
        if (out_free) begin
          emit_en                 = 1'b1;
          emit_res.result_kind    = RES_FRAME;
          emit_res.last_item      = 1'b1;
          emit_res.table_index    = 5'(fr_slot);
          emit_res.id_value       = in_q.arb_id;
          emit_res.id_tracked     = fr_trk;
          emit_res.frame_bits     = fr_bits;
          emit_res.count_value    = fr_cnt;
          state_next              = ST_IDLE;
        end
      end
      ST_ERR_OUT: begin
        if (out_free) begin
          emit_en              = 1'b1;
          emit_res.result_kind = RES_ERROR;
          emit_res.last_item   = 1'b1;
          emit_res.count_value = err_cnt;
          state_next           = ST_IDLE;
        end
      end
      ST_DROP_OUT: begin
        if (out_free) begin
          emit_en              = 1'b1;
          emit_res.result_kind = RES_DROP;
          emit_res.last_item   = 1'b1;
          emit_res.count_value = dropped_total;
          state_next           = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SUM_OUT;
        end
      end
      ST_SUM_OUT: begin
        if (out_free) begin
          emit_en                 = 1'b1;
          emit_res.result_kind    = RES_SUMMARY;
          emit_res.last_item      = (tracked_count == '0);
          emit_res.utilization_bp = util_q;
          emit_res.error_rate     = window_errors;
          state_next              = (tracked_count == '0) ? ST_IDLE : ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        tbl_rd_en  = 1'b1;
        state_next = ST_WALK_OUT;
      end
      ST_WALK_OUT: begin
        if (out_free) begin
          emit_en              = 1'b1;
          emit_res.result_kind = RES_RATE;
          emit_res.last_item   = walk_last;
          emit_res.table_index = 5'(ptr[TBL_AW-1:0]);
          emit_res.id_value    = rd_key;
          emit_res.count_value = rd_cnt;
          tbl_wr.cnt_en        = 1'b1;
          tbl_wr.addr          = ptr[TBL_AW-1:0];
          tbl_wr.cnt           = 32'd0;
          state_next           = walk_last ? ST_IDLE : ST_WALK_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      baud_rate     <= BAUD_RESET;
      tracked_count <= '0;
      bits_accum    <= '0;
      window_errors <= '0;
      dropped_total <= '0;
      state_of_bus  <= BUS_ACTIVE;
      pend          <= 1'b0;
      ptr           <= '0;
      for (int k = 0; k < KIND_COUNTS; k++) begin
        kind_cnt[k] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        baud_rate <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          ptr  <= '0;
          pend <= 1'b0;
          if (in_acc && (in_data.req_type == REQ_STATUS)) begin
            state_of_bus <= in_data.bus_off_flag ? BUS_OFF :
                            (in_data.passive_flag ? BUS_PASSIVE : BUS_ACTIVE);
            if (in_data.protocol_error) begin
              window_errors <= window_errors + 32'd1;
              if (ek_valid) begin
                kind_cnt[ek_idx] <= kind_cnt[ek_idx] + 32'd1;
              end
            end
          end
          if (in_acc && (in_data.req_type == REQ_LOST)) begin
            dropped_total <= dropped_total + 32'd1;
          end
        end
        ST_SCAN: begin
          if (hit || miss) begin
            bits_accum <= bits_sum[32] ? 32'hFFFF_FFFF : bits_sum[31:0];
            if (miss && room) begin
              tracked_count <= tracked_count + 1'b1;
            end
          end else begin
            pend <= ptr < tracked_count;
            if (ptr < tracked_count) begin
              ptr <= ptr + 1'b1;
            end
          end
        end
        ST_SUM_OUT: begin
          if (out_free) begin
            bits_accum    <= '0;
            window_errors <= '0;
            ptr           <= '0;
          end
        end
        ST_WALK_OUT: begin
          if (out_free) begin
            ptr <= ptr + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // per-request payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (in_acc) begin
        in_q <= in_data;
      end
      err_cnt <= (in_data.protocol_error && ek_valid) ? kind_cnt[ek_idx] + 32'd1 : 32'd0;
    end
    if (state == ST_SCAN) begin
      pidx    <= ptr[TBL_AW-1:0];
      fr_bits <= fb_now;
      if (hit) begin
        fr_slot <= pidx;
        fr_trk  <= 1'b1;
        fr_cnt  <= rd_cnt + 32'd1;
      end else if (miss) begin
        fr_slot <= room ? tracked_count[TBL_AW-1:0] : '0;
        fr_trk  <= room;
        fr_cnt  <= room ? 32'd1 : 32'd0;
      end
    end
    if (div_done) begin
      util_q <= div_util;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_data <= emit_res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    tracked_count <= CNT_W'(TRACKED_IDS))
    else $error("tracked ID count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !(tbl_wr.cnt_en || tbl_wr.key_en))
    else $error("table written while idle");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside a window tick");

  assert property (@(posedge clk) disable iff (rst)
    emit_en |-> out_free)
    else $error("result overwrote a pending transfer");

endmodule
